// ----- src/fca_pkg.sv -----
// shared types, field widths and codes for the fixed chunk allocator
// no dependencies; imported by fca_alu and fixed_chunk_allocator_top
package fca_pkg;

    localparam int unsigned ADDR_W         = 12;
    localparam int unsigned CHUNK_W        = 12;
    localparam int unsigned BIN_W          = 13;
    localparam int unsigned WILD_W         = 13;
    localparam int unsigned LINK_W         = 13;
    localparam int unsigned LINK_DEPTH     = 4096;
    localparam int unsigned STATUS_W       = 3;
    localparam int unsigned CFG_AW         = 3;
    localparam int unsigned CFG_DW         = 32;
    localparam int unsigned POOL_UNITS_DEF = 4096;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 12'd4;
    localparam logic [CHUNK_W-1:0] CHUNK_MIN   = 12'd2;
    localparam logic [BIN_W-1:0]   BIN_RESET   = 13'd256;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register select is byte address bit 2
    localparam logic REG_CHUNK = 1'b0;
    localparam logic REG_BIN   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_LIST  = 3'd0,
        ST_SPLIT = 3'd1,
        ST_EXACT = 3'd2,
        ST_BIN   = 3'd3,
        ST_FREED = 3'd4,
        ST_OOM   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BIN_A,
        S_BIN_B,
        S_BIN_C,
        S_BIN_D
    } t_state;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } t_alu_op;

    typedef struct packed {
        logic borrow;
        logic zero;
    } t_alu_flags;

endpackage

// ----- src/fca_ram.sv -----
// generic single-port ram with registered read data
// no dependencies; holds the free list links
module fca_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/fca_alu.sv -----
// shared add/subtract unit with borrow and zero flags
// depends on fca_pkg
module fca_alu
    import fca_pkg::*;
#(
    parameter int unsigned W = 17
) (
    input  t_alu_op     i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_res,
    output t_alu_flags   o_flags
);

    logic [W:0] w_full;

    always_comb begin
        case (i_op)
            ALU_ADD: w_full = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_full = {1'b0, i_a} - {1'b0, i_b};
            default: w_full = {1'b0, i_a} - {1'b0, i_b};
        endcase
    end

    assign o_res          = w_full[W-1:0];
    assign o_flags.borrow = (i_op == ALU_SUB) && w_full[W];
    assign o_flags.zero   = (w_full[W-1:0] == '0);

endmodule

// ----- src/fixed_chunk_allocator_top.sv -----
// top level of the fixed chunk allocator: config registers, sequencer, state
// depends on fca_pkg, fca_alu and fca_ram
//
// Each transaction served from the free list, by a free, or by a cut or exact fit of the
// wilderness passes through the accept cycle, which also starts the link ram read, and
// the execute state. An allocate that needs a new bin goes on through the bin states, as
// the shared add/subtract unit steps through the wilderness check, bin minus chunk size,
// the pool bound and the bump pointer update; an out-of-memory answer comes from S_BIN_A
// to S_BIN_C. A new transaction is taken once the sequencer is back in idle and the
// result register is empty or being drained in that cycle. The link ram needs no
// clearing after reset; reset returns the free list to empty and the pool to unused.
module fixed_chunk_allocator_top
    import fca_pkg::*;
#(
    parameter int unsigned POOL_UNITS = POOL_UNITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [ADDR_W-1:0]   i_free_addr,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ADDR_W-1:0]   o_payload_addr,
    output logic [STATUS_W-1:0] o_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [CFG_DW-1:0]   pwdata,
    output logic [CFG_DW-1:0]   prdata,
    output logic                pready
);

    localparam int unsigned PN_W = $clog2(POOL_UNITS + 1);
    localparam int unsigned AW   = (PN_W > BIN_W) ? PN_W : BIN_W;
    localparam logic [AW-1:0] POOL_VAL = AW'(POOL_UNITS);

    // configuration
    logic [CHUNK_W-1:0] r_chunk_units;
    logic [BIN_W-1:0]   r_bin_units;
    logic               w_cfg_wr;

    // control and allocator state
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_list_head, n_list_head;
    logic                r_list_empty, n_list_empty;
    logic [ADDR_W-1:0]   r_wild_base, n_wild_base;
    logic [WILD_W-1:0]   r_wild_size, n_wild_size;
    logic [PN_W-1:0]     r_pool_next, n_pool_next;
    logic                r_out_valid, n_out_valid;

    // payload registers
    logic                r_cmd, n_cmd;
    logic [ADDR_W-1:0]   r_free_addr, n_free_addr;
    logic [AW-1:0]       r_tmp_a, n_tmp_a;
    logic [AW-1:0]       r_tmp_b, n_tmp_b;
    logic [ADDR_W-1:0]   r_out_addr, n_out_addr;
    t_status             r_out_status, n_out_status;

    // datapath
    logic                w_accept;
    logic                w_out_take;
    logic [CHUNK_W-1:0]  w_csz;
    t_alu_op             w_alu_op;
    logic [AW-1:0]       w_alu_a, w_alu_b, w_alu_res;
    t_alu_flags          w_alu_flags;
    logic                w_split, w_exact, w_bin_ok;
    logic [ADDR_W-1:0]   w_addr_base, w_addr_off, w_addr_sum;
    logic [ADDR_W-1:0]   w_free_hdr;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_addr;
    logic [LINK_W-1:0]   w_ram_wdata, w_ram_rdata;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_units <= CHUNK_RESET;
            r_bin_units   <= BIN_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_CHUNK: r_chunk_units <= pwdata[CHUNK_W-1:0];
                REG_BIN:   r_bin_units   <= pwdata[BIN_W-1:0];
                default:   r_chunk_units <= r_chunk_units;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CHUNK: prdata = CFG_DW'(r_chunk_units);
            REG_BIN:   prdata = CFG_DW'(r_bin_units);
            default:   prdata = '0;
        endcase
    end

    // handshakes
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_valid && i_out_ready;

    assign w_csz      = (r_chunk_units < CHUNK_MIN) ? CHUNK_MIN : r_chunk_units;
    assign w_free_hdr = r_free_addr - ADDR_W'(1);

    fca_alu #(
        .W (AW)
    ) u_alu (
        .i_op    (w_alu_op),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_res   (w_alu_res),
        .o_flags (w_alu_flags)
    );

    fca_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    assign w_split    = !w_alu_flags.borrow && !w_alu_flags.zero;
    assign w_exact    = w_alu_flags.zero;
    assign w_bin_ok   = !w_alu_flags.borrow && !w_alu_flags.zero;
    assign w_addr_sum = w_addr_base + w_addr_off + ADDR_W'(1);

    // next state
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = w_accept ? S_EXEC : S_IDLE;
            S_EXEC: begin
                if (r_cmd == CMD_ALLOC && r_list_empty && !w_split && !w_exact) begin
                    n_state = S_BIN_A;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BIN_A: n_state = w_bin_ok ? S_BIN_B : S_IDLE;
            S_BIN_B: n_state = !w_alu_flags.borrow ? S_BIN_C : S_IDLE;
            S_BIN_C: n_state = !w_alu_flags.borrow ? S_BIN_D : S_IDLE;
            S_BIN_D: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: shared unit operands, address adder, link ram
    always_comb begin
        w_alu_op    = ALU_SUB;
        w_alu_a     = '0;
        w_alu_b     = '0;
        w_addr_base = r_list_head;
        w_addr_off  = '0;
        w_ram_we    = 1'b0;
        w_ram_addr  = r_list_head;
        w_ram_wdata = r_list_empty ? '0 : {1'b1, r_list_head};
        case (r_state)
            S_IDLE: begin
                // start the pop read on the current head
                w_ram_addr = r_list_head;
            end
            S_EXEC: begin
                w_alu_a    = AW'(r_wild_size);
                w_alu_b    = AW'(w_csz);
                w_ram_addr = w_free_hdr;
                w_ram_we   = (r_cmd == CMD_FREE) && (r_free_addr != '0);
                if (r_list_empty) begin
                    w_addr_base = r_wild_base;
                    w_addr_off  = w_split ? w_alu_res[ADDR_W-1:0] : '0;
                end
            end
            S_BIN_A: begin
                w_alu_a = AW'(r_bin_units);
                w_alu_b = AW'(w_csz);
            end
            S_BIN_B: begin
                w_alu_a = POOL_VAL;
                w_alu_b = AW'(r_bin_units);
            end
            S_BIN_C: begin
                w_alu_a = r_tmp_b;
                w_alu_b = AW'(r_pool_next);
            end
            S_BIN_D: begin
                w_alu_op    = ALU_ADD;
                w_alu_a     = AW'(r_pool_next);
                w_alu_b     = AW'(r_bin_units);
                w_addr_base = ADDR_W'(r_pool_next);
                w_addr_off  = r_tmp_a[ADDR_W-1:0];
            end
            default: begin
                w_alu_op = ALU_SUB;
            end
        endcase
    end

    // register updates
    always_comb begin
        n_list_head  = r_list_head;
        n_list_empty = r_list_empty;
        n_wild_base  = r_wild_base;
        n_wild_size  = r_wild_size;
        n_pool_next  = r_pool_next;
        n_cmd        = r_cmd;
        n_free_addr  = r_free_addr;
        n_tmp_a      = r_tmp_a;
        n_tmp_b      = r_tmp_b;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_valid  = r_out_valid && !w_out_take;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd       = i_command;
                    n_free_addr = i_free_addr;
                end
            end
            S_EXEC: begin
                if (r_cmd == CMD_FREE) begin
                    if (r_free_addr != '0) begin
                        n_list_head  = w_free_hdr;
                        n_list_empty = 1'b0;
                    end
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_FREED;
                end else if (!r_list_empty) begin
                    if (w_ram_rdata[LINK_W-1]) begin
                        n_list_head = w_ram_rdata[ADDR_W-1:0];
                    end else begin
                        n_list_empty = 1'b1;
                    end
                    n_out_valid  = 1'b1;
                    n_out_addr   = w_addr_sum;
                    n_out_status = ST_LIST;
                end else if (w_split) begin
                    n_wild_size  = w_alu_res[WILD_W-1:0];
                    n_out_valid  = 1'b1;
                    n_out_addr   = w_addr_sum;
                    n_out_status = ST_SPLIT;
                end else if (w_exact) begin
                    n_wild_size  = '0;
                    n_out_valid  = 1'b1;
                    n_out_addr   = w_addr_sum;
                    n_out_status = ST_EXACT;
                end
            end
            S_BIN_A: begin
                // bin must be larger than a chunk
                if (w_bin_ok) begin
                    n_tmp_a = w_alu_res;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_OOM;
                end
            end
            S_BIN_B: begin
                if (!w_alu_flags.borrow) begin
                    n_tmp_b = w_alu_res;
                end else begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_OOM;
                end
            end
            S_BIN_C: begin
                // pool_next must not pass pool size minus bin
                if (w_alu_flags.borrow) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = '0;
                    n_out_status = ST_OOM;
                end
            end
            S_BIN_D: begin
                n_wild_base  = ADDR_W'(r_pool_next);
                n_pool_next  = w_alu_res[PN_W-1:0];
                n_wild_size  = WILD_W'(r_tmp_a);
                n_out_valid  = 1'b1;
                n_out_addr   = w_addr_sum;
                n_out_status = ST_BIN;
            end
            default: begin
                n_out_valid = r_out_valid && !w_out_take;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_list_head  <= '0;
            r_list_empty <= 1'b1;
            r_wild_base  <= '0;
            r_wild_size  <= '0;
            r_pool_next  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_list_head  <= n_list_head;
            r_list_empty <= n_list_empty;
            r_wild_base  <= n_wild_base;
            r_wild_size  <= n_wild_size;
            r_pool_next  <= n_pool_next;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_free_addr  <= n_free_addr;
        r_tmp_a      <= n_tmp_a;
        r_tmp_b      <= n_tmp_b;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_addr = r_out_addr;
    assign o_status       = r_out_status;

endmodule
